/* rtl/fmd_pkg.sv */
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared constants and types for the frame difference motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fmd_pkg;

    // pixel and register widths
    localparam int PIX_W = 8;
    localparam int CFG_W = 8;
    localparam int CFG_INDEX_W = 1;

    // stream payload widths
    localparam int S_TDATA_W = 4 * PIX_W;
    localparam int M_TDATA_W = 24;

    // frame counters saturate at all ones
    localparam int COUNT_W = 23;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // line buffer depth default
    localparam int DEFAULT_MAX_WIDTH = 2048;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DEVIATION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_THRESHOLD = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] MAX_DEVIATION_RESET = 8'd50;
    localparam logic [CFG_W-1:0] DIFF_THRESHOLD_RESET = 8'd35;

    // rgb to gray weights, fixed point with 14 fraction bits
    localparam int GRAY_SUM_W = 23;
    localparam int GRAY_SHIFT = 14;
    localparam logic [GRAY_SUM_W-1:0] COEF_R = 23'd4899;
    localparam logic [GRAY_SUM_W-1:0] COEF_G = 23'd9617;
    localparam logic [GRAY_SUM_W-1:0] COEF_B = 23'd1868;
    localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 23'd8192;

    // summary queue depth
    localparam int QUEUE_DEPTH = 2;

    // per-frame summary handed from the pixel front to the decision back
    typedef struct packed {
        logic [COUNT_W-1:0] kept;
        logic [COUNT_W-1:0] total;
    } frame_sum_t;

endpackage

`default_nettype wire

/* rtl/frame_difference_motion_detect.sv */
// ----------------------------------------------------------------------------
// frame_difference_motion_detect
// Frame difference motion detector with 2x2 erosion and per-frame decision.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one pixel item per cycle in raster order unless
//   stalled: previous gray and new RGB in s_tdata, row end in s_tuser,
//   frame end in s_tlast. The m_ channel gives one item per frame: the
//   motion flag and the count of pixels that survive erosion.
//   Throughput is one pixel item per cycle while no frame end waits on a full
//   summary queue; the line buffer is read when an item is taken and written
//   when that item leaves stage 1, with a bypass for the same column.
//   The frame result goes from stage 1 through a two-entry summary queue to
//   the decision back, which captures it, forms the products, scales and
//   squares them, then compares and loads the output register.
//   If the receiver stalls, the result waits in the output register and
//   pixels keep flowing; only when two more frame summaries are queued does
//   s_tready drop, on the next frame-end item.
//   Reset sets max_deviation to 50 and diff_threshold to 35, clears the
//   counters and position, and starts a new frame at row 0, column 0.
//   Registers go through cfg_we / cfg_index / cfg_wdata, by the user only while idle; the block has no check.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_difference_motion_detect #(
    parameter int MAX_WIDTH = fmd_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // register write port
    input  wire logic                              cfg_we,
    input  wire logic [fmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fmd_pkg::CFG_W-1:0]         cfg_wdata,
    // pixel items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // prev_gray [7:0], red [15:8], green [23:16], blue [31:24]
    input  wire logic [fmd_pkg::S_TDATA_W-1:0]     s_tdata,
    // row_end [0]
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    // frame result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // motion [0], changed_count [23:1]
    output logic [fmd_pkg::M_TDATA_W-1:0]          m_tdata
);

    logic [fmd_pkg::CFG_W-1:0] max_deviation_reg;
    logic [fmd_pkg::CFG_W-1:0] diff_threshold_reg;

    logic                q_push_valid;
    logic                q_push_ready;
    fmd_pkg::frame_sum_t q_push_data;
    logic                q_pop_valid;
    logic                q_pop_ready;
    fmd_pkg::frame_sum_t q_pop_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_deviation_reg  <= fmd_pkg::MAX_DEVIATION_RESET;
            diff_threshold_reg <= fmd_pkg::DIFF_THRESHOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fmd_pkg::REG_MAX_DEVIATION:  max_deviation_reg  <= cfg_wdata;
                fmd_pkg::REG_DIFF_THRESHOLD: diff_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pixel front
    fmd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .diff_threshold (diff_threshold_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .sum_valid      (q_push_valid),
        .sum_ready      (q_push_ready),
        .sum_data       (q_push_data)
    );

    // frame summary queue
    fmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // decision back
    fmd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .max_deviation (max_deviation_reg),
        .sum_valid     (q_pop_valid),
        .sum_ready     (q_pop_ready),
        .sum_data      (q_pop_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

`default_nettype wire

/* rtl/fmd_ram.sv */
// ----------------------------------------------------------------------------
// fmd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/fmd_front.sv */
// ----------------------------------------------------------------------------
// fmd_front
// Pixel front: gray conversion, change marking, 2x2 erosion over a line
// buffer, and per-frame kept/total counting.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_front #(
    parameter int MAX_WIDTH = fmd_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [fmd_pkg::CFG_W-1:0]      diff_threshold,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [fmd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           s_tlast,
    output logic                                sum_valid,
    input  wire logic                           sum_ready,
    output fmd_pkg::frame_sum_t                 sum_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
    localparam int PW = fmd_pkg::PIX_W;
    localparam int CW = fmd_pkg::COUNT_W;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == fmd_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // input fields
    logic [PW-1:0] in_prev;
    logic [PW-1:0] in_red;
    logic [PW-1:0] in_green;
    logic [PW-1:0] in_blue;
    logic [fmd_pkg::GRAY_SUM_W-1:0] gray_sum;

    // position state
    logic [COL_W-1:0] col_reg, col_next;
    logic             first_row_reg, first_row_next;

    // second stage
    logic             s1_valid_reg, s1_valid_next;
    logic [PW-1:0]    s1_gray_reg;
    logic [PW-1:0]    s1_prev_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_at_left_reg;
    logic             s1_top_reg;
    logic             s1_row_end_reg;
    logic             s1_frame_end_reg;
    logic             byp_hit_reg;
    logic             byp_mark_reg;

    // erosion and counting state
    logic             left_reg, left_next;
    logic             upper_left_reg, upper_left_next;
    logic [CW-1:0]    kept_reg, kept_next;
    logic [CW-1:0]    total_reg, total_next;

    logic             accept;
    logic             s1_fire;
    logic             ram_q;
    logic             up_raw;
    logic [PW-1:0]    diff;
    logic             mark;
    logic             keep;
    logic [CW-1:0]    kept_inc;
    logic [CW-1:0]    total_inc;

    assign in_prev  = s_tdata[0*PW +: PW];
    assign in_red   = s_tdata[1*PW +: PW];
    assign in_green = s_tdata[2*PW +: PW];
    assign in_blue  = s_tdata[3*PW +: PW];

    // handshake: stage 1 only holds on a frame end with the queue full
    assign s1_fire  = s1_valid_reg && (!s1_frame_end_reg || sum_ready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign accept   = s_tvalid && s_tready;

    // gray conversion on the incoming item
    assign gray_sum = fmd_pkg::COEF_R * fmd_pkg::GRAY_SUM_W'(in_red)
                    + fmd_pkg::COEF_G * fmd_pkg::GRAY_SUM_W'(in_green)
                    + fmd_pkg::COEF_B * fmd_pkg::GRAY_SUM_W'(in_blue)
                    + fmd_pkg::GRAY_ROUND;

    // column and row tracking at accept time
    always_comb begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept) begin
            if (s_tlast) begin
                col_next       = '0;
                first_row_next = 1'b1;
            end else if (s_tuser) begin
                col_next       = '0;
                first_row_next = 1'b0;
            end else if (col_reg != COL_LAST) begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // line buffer of raw marks from the row above
    fmd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (mark),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_q)
    );

    // mark and erosion window
    always_comb begin
        diff   = (s1_gray_reg > s1_prev_reg) ? s1_gray_reg - s1_prev_reg
                                             : s1_prev_reg - s1_gray_reg;
        mark   = diff > diff_threshold;
        up_raw = byp_hit_reg ? byp_mark_reg : ram_q;
        keep   = mark
              && (s1_at_left_reg || left_reg)
              && (s1_top_reg || up_raw)
              && (s1_at_left_reg || s1_top_reg || upper_left_reg);
    end

    // counters and neighbor marks
    always_comb begin
        total_inc       = sat_inc(total_reg);
        kept_inc        = keep ? sat_inc(kept_reg) : kept_reg;
        kept_next       = kept_reg;
        total_next      = total_reg;
        left_next       = left_reg;
        upper_left_next = upper_left_reg;
        if (s1_fire) begin
            if (s1_frame_end_reg) begin
                kept_next       = '0;
                total_next      = '0;
                left_next       = 1'b0;
                upper_left_next = 1'b0;
            end else begin
                kept_next  = kept_inc;
                total_next = total_inc;
                if (s1_row_end_reg) begin
                    left_next       = 1'b0;
                    upper_left_next = 1'b0;
                end else begin
                    left_next       = mark;
                    upper_left_next = up_raw;
                end
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    // summary push on frame end
    assign sum_valid      = s1_valid_reg && s1_frame_end_reg;
    assign sum_data.kept  = kept_inc;
    assign sum_data.total = total_inc;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            first_row_reg  <= 1'b1;
            s1_valid_reg   <= 1'b0;
            left_reg       <= 1'b0;
            upper_left_reg <= 1'b0;
            kept_reg       <= '0;
            total_reg      <= '0;
        end else begin
            col_reg        <= col_next;
            first_row_reg  <= first_row_next;
            s1_valid_reg   <= s1_valid_next;
            left_reg       <= left_next;
            upper_left_reg <= upper_left_next;
            kept_reg       <= kept_next;
            total_reg      <= total_next;
        end
    end

    // stage 1 payload, with bypass of the mark written in the same cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_gray_reg      <= gray_sum[fmd_pkg::GRAY_SHIFT +: PW];
            s1_prev_reg      <= in_prev;
            s1_col_reg       <= col_reg;
            s1_at_left_reg   <= (col_reg == '0);
            s1_top_reg       <= first_row_reg;
            s1_row_end_reg   <= s_tuser;
            s1_frame_end_reg <= s_tlast;
            byp_hit_reg      <= s1_fire && (s1_col_reg == col_reg);
            byp_mark_reg     <= mark;
        end
    end

endmodule

`default_nettype wire

/* rtl/fmd_queue.sv */
// ----------------------------------------------------------------------------
// fmd_queue
// Short queue of frame summaries between the pixel front and decision back.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire fmd_pkg::frame_sum_t push_data,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output fmd_pkg::frame_sum_t      pop_data
);

    localparam int DEPTH = fmd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fmd_pkg::frame_sum_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/fmd_back.sv */
// ----------------------------------------------------------------------------
// fmd_back
// Decision back: per-frame deviation test 65025*n*(N-n) > dev^2*N^2 and
// the registered result item.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [fmd_pkg::CFG_W-1:0]     max_deviation,
    input  wire logic                          sum_valid,
    output logic                               sum_ready,
    input  wire fmd_pkg::frame_sum_t           sum_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fmd_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int CW     = fmd_pkg::COUNT_W;
    localparam int DW     = fmd_pkg::CFG_W;
    localparam int PROD_W = 2 * CW;
    localparam int DN_W   = DW + CW;
    localparam int CMP_W  = 2 * DN_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_DONE  = 4'b1000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     tot_reg;
    logic [CW-1:0]     rest_reg;
    logic [DW-1:0]     dev_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DN_W-1:0]   dev_tot_reg;
    logic [CMP_W-1:0]  lhs_reg;
    logic [CMP_W-1:0]  rhs_reg;
    logic              m_valid_reg, m_valid_next;
    logic              motion_reg;
    logic [CW-1:0]     count_reg;
    logic              out_free;
    logic              load_out;
    logic [CMP_W-1:0]  prod_ext;

    assign out_free  = !m_valid_reg || m_tready;
    assign sum_ready = (state_reg == ST_IDLE);
    assign load_out  = (state_reg == ST_DONE) && out_free;
    assign prod_ext  = CMP_W'(prod_reg);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (sum_valid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // output valid: set on load, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // operand capture
    always_ff @(posedge aclk) begin
        if (sum_ready && sum_valid) begin
            n_reg    <= sum_data.kept;
            tot_reg  <= sum_data.total;
            rest_reg <= sum_data.total - sum_data.kept;
            dev_reg  <= max_deviation;
        end
    end

    // first products: n*(N-n) and dev*N
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            prod_reg    <= PROD_W'(n_reg) * PROD_W'(rest_reg);
            dev_tot_reg <= DN_W'(dev_reg) * DN_W'(tot_reg);
        end
    end

    // 65025 = 2^16 - 2^9 + 1, and the square of dev*N
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCALE) begin
            lhs_reg <= (prod_ext << 16) - (prod_ext << 9) + prod_ext;
            rhs_reg <= CMP_W'(dev_tot_reg) * CMP_W'(dev_tot_reg);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            motion_reg <= (lhs_reg > rhs_reg);
            count_reg  <= n_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {count_reg, motion_reg};

endmodule

`default_nettype wire

/* rtl/fmd_checker.sv */
// ----------------------------------------------------------------------------
// fmd_checker
// Port-level checks for the frame difference motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

module fmd_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [fmd_pkg::M_TDATA_W-1:0]     m_tdata
);

    // a stalled result item stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // motion needs at least one kept pixel
    a_motion_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[23:1] != '0)
        else $error("motion reported with zero kept pixels");

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result item offered out of reset");

endmodule

bind frame_difference_motion_detect fmd_checker u_fmd_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame difference motion detector. A short
// directed table covers the extremes, both register settings and the erosion
// corner cases. Random frames follow: mostly well-formed rasters with
// random changes, plus ragged and noisy frames and one overlong row pair.
// Every frame result is checked field by field against the typed result of
// a directed row, else against a predictor of the gray conversion, the 2x2 erosion and the deviation test.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import fmd_pkg::*;

    // narrow line buffer so the overlong rows stay short
    localparam int LINE_W = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED = 26;

    typedef struct packed {
        logic               motion;
        logic [COUNT_W-1:0] changed_count;
    } motion_report_t;

    typedef struct {
        logic [7:0] prev_gray;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } pixel_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // one table row: a pixel item or a register write, typed result optional
    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_W-1:0]       reg_value;
        logic [7:0]             prev_gray;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic                   row_end;
        logic                   frame_end;
        bit                     typed;
        logic                   motion;
        logic [COUNT_W-1:0]     changed_count;
    } directed_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    // predictor state
    logic [CFG_W-1:0]   dev_limit = MAX_DEVIATION_RESET;
    logic [CFG_W-1:0]   thr_level = DIFF_THRESHOLD_RESET;
    bit                 line_marks [LINE_W];
    bit                 left_mark = 1'b0;
    bit                 upper_left_mark = 1'b0;
    int                 col_pos = 0;
    bit                 on_first_row = 1'b1;
    logic [COUNT_W-1:0] kept_pixels = '0;
    logic [COUNT_W-1:0] frame_pixels = '0;
    int                 line_filled = 0;

    motion_report_t pending_reports [$];
    int             mismatch_count = 0;
    int             reports_seen = 0;
    int             random_items = 0;
    int             cycle_count = 0;
    int             gap_rate = 2;
    bit             calm = 1'b0;

    // gray level (changed) pixel then (unchanged) pixel patterns
    directed_row_t directed_rows [N_DIRECTED] = '{
        // single pixel frame, full swing
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
          1'b0, 1'b1, 1'b1, 1'b0, 23'd1},
        // 2x2 all changed, last item ends row and frame
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          1'b1, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          1'b1, 1'b1, 1'b1, 1'b0, 23'd4},
        // 2x2 with the corner unchanged: erosion removes everything
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          1'b1, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b1, 1'b1, 1'b0, 23'd0},
        // difference one above and exactly at the threshold
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd255, 8'd219, 8'd219, 8'd219,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd35, 8'd35, 8'd35,
          1'b0, 1'b1, 1'b1, 1'b1, 23'd1},
        // zero deviation limit
        '{ROW_WRITE, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd200, 8'd200, 8'd200,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd200, 8'd200, 8'd200, 8'd200,
          1'b0, 1'b1, 1'b1, 1'b1, 23'd1},
        // full deviation limit, never reached
        '{ROW_WRITE, REG_MAX_DEVIATION, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd200, 8'd200, 8'd200,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd200, 8'd200, 8'd200, 8'd200,
          1'b0, 1'b1, 1'b1, 1'b0, 23'd1},
        // full threshold: nothing can change
        '{ROW_WRITE, REG_DIFF_THRESHOLD, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
          1'b0, 1'b1, 1'b1, 1'b0, 23'd0},
        // zero threshold: a difference of one counts
        '{ROW_WRITE, REG_DIFF_THRESHOLD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd7, 8'd8, 8'd8, 8'd8,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd8, 8'd8, 8'd8, 8'd8,
          1'b0, 1'b1, 1'b0, 1'b0, 23'd0},
        // single channel weights
        '{ROW_WRITE, REG_DIFF_THRESHOLD, 8'd35, 8'd0, 8'd0, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0,
          1'b0, 1'b0, 1'b0, 1'b0, 23'd0},
        '{ROW_PIXEL, REG_MAX_DEVIATION, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
          1'b0, 1'b1, 1'b0, 1'b0, 23'd0}
    };

    frame_difference_motion_detect #(
        .MAX_WIDTH (LINE_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // rgb to gray, 14 fraction bits with rounding
    function automatic int unsigned to_gray(input logic [7:0] r, g, b);
        return (4899 * r + 9617 * g + 1868 * b + 8192) >> 14;
    endfunction

    // advance the detector by one pixel, returns 1 with the frame result
    function automatic bit detect_pixel(input pixel_t p, output motion_report_t rep);
        int unsigned     gray;
        int unsigned     diff;
        bit              mark;
        bit              up_mark;
        bit              at_left;
        bit              keep;
        longint unsigned n;
        longint unsigned total;
        longint unsigned dev;
        gray = to_gray(p.red, p.green, p.blue);
        diff = (gray > p.prev_gray) ? gray - p.prev_gray : p.prev_gray - gray;
        mark = diff > thr_level;
        up_mark = line_marks[col_pos];
        at_left = (col_pos == 0);
        keep = mark && (at_left || left_mark) && (on_first_row || up_mark)
            && (at_left || on_first_row || upper_left_mark);

        if (frame_pixels != COUNT_MAX) frame_pixels++;
        if (keep && kept_pixels != COUNT_MAX) kept_pixels++;

        line_marks[col_pos] = mark;
        if (col_pos + 1 > line_filled) line_filled = col_pos + 1;
        upper_left_mark = up_mark;
        left_mark = mark;
        rep = '0;

        if (p.frame_end) begin
            n = kept_pixels;
            total = frame_pixels;
            dev = dev_limit;
            rep.motion = (65025 * (n * (total - n))) > (dev * dev * (total * total));
            rep.changed_count = kept_pixels;
            left_mark = 1'b0;
            upper_left_mark = 1'b0;
            col_pos = 0;
            on_first_row = 1'b1;
            kept_pixels = '0;
            frame_pixels = '0;
            return 1'b1;
        end

        // row end restarts the column, an overlong row sticks at the last slot
        if (p.row_end) begin
            col_pos = 0;
            on_first_row = 1'b0;
            left_mark = 1'b0;
            upper_left_mark = 1'b0;
        end else if (col_pos < LINE_W - 1) begin
            col_pos++;
        end
        return 1'b0;
    endfunction

    // previous gray on the far side of the new gray, inside or outside threshold
    function automatic logic [7:0] pick_prev_gray(input int gray, input bit changed);
        int room;
        int d;
        room = (gray >= 128) ? gray : 255 - gray;
        if (changed) begin
            if (room <= int'(thr_level)) return 8'($urandom_range(0, 255));
            d = $urandom_range(room, int'(thr_level) + 1);
        end else begin
            d = $urandom_range((int'(thr_level) < room) ? int'(thr_level) : room, 0);
        end
        return 8'((gray >= 128) ? gray - d : gray + d);
    endfunction

    function automatic pixel_t make_pixel(input bit changed, input bit noise);
        pixel_t p;
        p.red = 8'($urandom);
        p.green = 8'($urandom);
        p.blue = 8'($urandom);
        p.prev_gray = noise ? 8'($urandom)
            : pick_prev_gray(int'(to_gray(p.red, p.green, p.blue)), changed);
        p.row_end = 1'b0;
        p.frame_end = 1'b0;
        return p;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("frame result %0d: %s got %0d expected %0d", reports_seen, field, got,
                 want);
        mismatch_count++;
    endtask

    // drive one pixel item and wait for it to be taken
    task automatic send_pixel(input pixel_t p, input bit typed, input motion_report_t typed_rep);
        motion_report_t rep;
        if (!calm && gap_rate != 0 && $urandom_range(0, 12 / gap_rate) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.blue, p.green, p.red, p.prev_gray};
        s_tuser <= p.row_end;
        s_tlast <= p.frame_end;
        do @(posedge aclk); while (!s_tready);
        if (detect_pixel(p, rep)) pending_reports.push_back(typed ? typed_rep : rep);
        @(negedge aclk);
    endtask

    // let every pending result out and the back stage settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_DEVIATION) dev_limit = val;
        else thr_level = val;
        @(negedge aclk);
    endtask

    task automatic send_frame(input int row_lens [$], input int mark_pct, input bit noise,
                              input bit last_row_end);
        pixel_t p;
        int     last;
        last = row_lens.size() - 1;
        for (int r = 0; r <= last; r++) begin
            for (int c = 0; c < row_lens[r]; c++) begin
                p = make_pixel($urandom_range(0, 99) < mark_pct, noise);
                p.frame_end = (r == last) && (c == row_lens[r] - 1);
                p.row_end = (c == row_lens[r] - 1) && (!p.frame_end || last_row_end);
                send_pixel(p, 1'b0, '0);
            end
        end
    endtask

    // small raster, sometimes ragged or noisy; later rows stay on written slots
    task automatic send_random_frame();
        int row_lens [$];
        int width;
        int height;
        int filled;
        int len;
        bit ragged;
        width = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        height = $urandom_range(1, 8);
        ragged = ($urandom_range(0, 5) == 0);
        filled = line_filled;
        gap_rate = $urandom_range(0, 3);
        for (int r = 0; r < height; r++) begin
            if (r == 0) begin
                len = ragged ? $urandom_range(1, width) : width;
                if (len > filled) filled = len;
            end else begin
                len = ragged ? $urandom_range(1, (filled < 48) ? filled : 48) : width;
            end
            row_lens.push_back(len);
            random_items += len;
        end
        send_frame(row_lens, $urandom_range(0, 4) * 25, $urandom_range(0, 7) == 0,
                   1'($urandom_range(0, 1)));
        if (random_items >= RANDOM_ITEMS - 150) calm = 1'b1;
    endtask

    // receiver with stall bursts at a slowly changing rate
    initial begin : receiver
        int rate;
        int span;
        m_tready = 1'b0;
        rate = 0;
        span = 0;
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                rate = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
            end
            span--;
            if (!calm && rate != 0 && $urandom_range(0, 12 / rate) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        motion_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", m_tdata, 0);
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[0] !== want.motion)
                    report_mismatch("motion", m_tdata[0], want.motion);
                if (m_tdata[M_TDATA_W-1:1] !== want.changed_count)
                    report_mismatch("changed_count", m_tdata[M_TDATA_W-1:1],
                                    want.changed_count);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("frame_difference_motion_detect: mismatch");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        directed_row_t  row;
        pixel_t         p;
        motion_report_t typed_rep;
        logic [CFG_W-1:0] new_limit;
        logic [CFG_W-1:0] new_thr;
        int             frames_left;
        bit             overlong_done;
        int             long_rows [$];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        frames_left = 0;
        overlong_done = 1'b0;
        foreach (line_marks[i]) line_marks[i] = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                wait_idle();
                write_reg(row.reg_index, row.reg_value);
            end else begin
                p.prev_gray = row.prev_gray;
                p.red = row.red;
                p.green = row.green;
                p.blue = row.blue;
                p.row_end = row.row_end;
                p.frame_end = row.frame_end;
                typed_rep.motion = row.motion;
                typed_rep.changed_count = row.changed_count;
                send_pixel(p, row.typed, typed_rep);
            end
        end

        // random frames in phases of register settings
        while (random_items < RANDOM_ITEMS) begin
            if (frames_left == 0) begin
                wait_idle();
                case ($urandom_range(0, 3))
                    0: new_limit = 8'd0;
                    1: new_limit = 8'd255;
                    default: new_limit = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 7))
                    0: new_thr = 8'd0;
                    1: new_thr = 8'd255;
                    default: new_thr = 8'($urandom_range(0, 80));
                endcase
                write_reg(REG_MAX_DEVIATION, new_limit);
                write_reg(REG_DIFF_THRESHOLD, new_thr);
                frames_left = $urandom_range(2, 8);
            end
            // one frame with rows past the line buffer end
            if (!overlong_done && reports_seen >= 15) begin
                long_rows = '{LINE_W + 2, LINE_W + 2};
                random_items += 2 * (LINE_W + 2);
                send_frame(long_rows, 90, 1'b0, 1'b1);
                overlong_done = 1'b1;
            end else begin
                send_random_frame();
            end
            frames_left--;
        end

        // drain
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("frame_difference_motion_detect: match");
        end else begin
            $display("frame_difference_motion_detect: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
